@@ hdl/ddo_pkg.sv @@
// Shared constants, item side-band types and helper functions for the
// differential-drive odometry step. Depends on nothing.
package ddo_pkg;

	localparam int CW         = 34;
	localparam int Q_W        = 52;
	localparam int DIV1_STEPS = 52;
	localparam int DIV2_STEPS = 42;

	localparam logic [19:0] DPT_RESET = 20'd212336;
	localparam logic [19:0] WB_RESET  = 20'd27085;

	localparam logic [1:0] REG_DPT = 2'd0;
	localparam logic [1:0] REG_WB  = 2'd1;

	localparam logic [28:0] INV4PI = 29'd341782638;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] HALF_TURN   = 34'sd2147483648;
	localparam logic signed [CW-1:0] QUARTER     = 34'sd1073741824;

	localparam logic signed [CW-1:0] ATAN_TURNS [0:23] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};

	typedef struct packed {
		logic [15:0]        hd;
		logic               neg;
		logic signed [37:0] dsum;
	} ddo_side1_t;

	typedef struct packed {
		logic [Q_W-1:0]     q;
		logic signed [37:0] dsum;
		logic [15:0]        dh;
		logic               small_turn;
	} ddo_side2_t;

	typedef struct packed {
		ddo_side2_t b;
		logic       flip_s;
		logic       flip_d;
	} ddo_side3_t;

	typedef struct packed {
		ddo_side2_t           b;
		logic                 s_neg;
		logic signed [CW-1:0] sn;
		logic signed [CW-1:0] cs;
	} ddo_side4_t;

	typedef struct packed {
		logic signed [CW-1:0] z;
		logic                 flip;
	} ddo_pre_t;

	// Folds an angle in 2^-32 turn into the right half plane.
	function automatic ddo_pre_t ddo_prerot(input logic [31:0] ang);
		logic signed [CW-1:0] z;
		ddo_pre_t res;
		z = CW'(signed'(ang));
		res.flip = 1'b0;
		res.z = z;
		if (z > QUARTER) begin
			res.z = z - HALF_TURN;
			res.flip = 1'b1;
		end else if (z < -QUARTER) begin
			res.z = z + HALF_TURN;
			res.flip = 1'b1;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] ddo_sat_sign(input logic neg, input logic [31:0] mag);
		logic [31:0] r;
		if (neg) begin
			r = (mag > 32'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
		end else begin
			r = mag[31] ? 32'h7fff_ffff : mag;
		end
		return signed'(r);
	endfunction

endpackage

@@ hdl/ddo_if.sv @@
// Handshake interfaces for the odometry step: input items, result items
// and configuration writes. Depends on nothing.
interface ddo_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_ticks;
	logic signed [15:0] right_ticks;
	logic [15:0]        heading;
	modport source(output valid, left_ticks, right_ticks, heading, input ready);
	modport sink(input valid, left_ticks, right_ticks, heading, output ready);
endinterface

interface ddo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] delta_x;
	logic signed [31:0] delta_y;
	logic signed [15:0] delta_heading;
	logic [30:0]        distance;
	modport source(output valid, delta_x, delta_y, delta_heading, distance, input ready);
	modport sink(input valid, delta_x, delta_y, delta_heading, distance, output ready);
endinterface

interface ddo_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [19:0] data;
	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

@@ hdl/ddo_div_cell.sv @@
// One restoring-division cell: decides one quotient bit and registers the
// partial remainder. Depends on nothing.
module ddo_div_cell #(
	parameter int DW = 20,
	parameter int NW = 52
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] d_i,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] num_i,
	output logic [DW-1:0] rem_o,
	output logic [NW-1:0] num_o
);

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {rem_i, num_i[NW-1]};
	assign diff  = trial - {1'b0, d_i};
	assign ge    = trial >= {1'b0, d_i};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_o <= {num_i[NW-2:0], ge};
		end
	end

endmodule

@@ hdl/ddo_cordic_cell.sv @@
// One CORDIC rotation cell with a fixed shift and arctangent step.
// Depends on ddo_pkg.
module ddo_cordic_cell import ddo_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] x_i,
	input  logic signed [CW-1:0] y_i,
	input  logic signed [CW-1:0] z_i,
	output logic signed [CW-1:0] x_o,
	output logic signed [CW-1:0] y_o,
	output logic signed [CW-1:0] z_o
);

	logic signed [CW-1:0] xsh;
	logic signed [CW-1:0] ysh;

	assign xsh = x_i >>> IDX;
	assign ysh = y_i >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_i >= 0) begin
				x_o <= x_i - ysh;
				y_o <= y_i + xsh;
				z_o <= z_i - ATAN_TURNS[IDX];
			end else begin
				x_o <= x_i + ysh;
				y_o <= y_i - xsh;
				z_o <= z_i + ATAN_TURNS[IDX];
			end
		end
	end

endmodule

@@ hdl/diff_drive_odometry_step.sv @@
// Top level of the differential-drive odometry step: two division chains,
// two CORDIC chains and the scaling multipliers.
// Depends on ddo_pkg, ddo_if, ddo_div_cell and ddo_cordic_cell.
//
//   channel   role     handshake      payload
//   odo_in    sink     valid/ready    left_ticks, right_ticks, heading
//   odo_out   source   valid/ready    delta_x, delta_y, delta_heading, distance
//   cfg       sink     valid/ready    addr, data (always ready)
//
// One item enters per cycle while no result is held; each passes through
// the 52 and 42 cell division chains and the CORDIC chain.
// Reset clears the valid bits and loads the register defaults.
// A held result stalls the whole pipeline until it is taken.
module diff_drive_odometry_step import ddo_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input logic        clk,
	input logic        arst_n,
	ddo_in_if.sink     odo_in,
	ddo_out_if.source  odo_out,
	ddo_cfg_if.sink    cfg
);

	localparam int N = CORDIC_STAGES;

	logic        en;
	logic [19:0] dpt_q;
	logic [19:0] wb_q;
	logic [19:0] wb_eff;

	assign en           = !odo_out.valid || odo_out.ready;
	assign odo_in.ready = en;
	assign cfg.ready    = 1'b1;
	assign wb_eff       = (wb_q == 20'd0) ? 20'd1 : wb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q <= DPT_RESET;
			wb_q  <= WB_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				REG_DPT: dpt_q <= cfg.data;
				REG_WB:  wb_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input stage: wheel difference, wheel sum and their scaling.
	logic signed [16:0] diff_c;
	logic signed [16:0] sum_c;
	logic signed [16:0] nabs_c;
	logic signed [20:0] dpt_s;
	logic [35:0]        ndpt_s1;
	ddo_side1_t         sd_s1;
	logic               v_s1;

	assign diff_c = 17'(odo_in.left_ticks) - 17'(odo_in.right_ticks);
	assign sum_c  = 17'(odo_in.left_ticks) + 17'(odo_in.right_ticks);
	assign nabs_c = diff_c[16] ? -diff_c : diff_c;
	assign dpt_s  = signed'({1'b0, dpt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= odo_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ndpt_s1      <= 36'(nabs_c[15:0]) * 36'(dpt_q);
			sd_s1.dsum   <= 38'(sum_c) * 38'(dpt_s);
			sd_s1.neg    <= diff_c[16];
			sd_s1.hd     <= odo_in.heading;
		end
	end

	// Heading change in radians: q = (n * dpt << 16) / wheel_base.
	logic [19:0]    r1  [0:DIV1_STEPS];
	logic [Q_W-1:0] n1  [0:DIV1_STEPS];
	ddo_side1_t     sd1 [0:DIV1_STEPS];
	logic           v1  [0:DIV1_STEPS];

	assign r1[0]  = 20'd0;
	assign n1[0]  = {ndpt_s1, 16'd0};
	assign sd1[0] = sd_s1;
	assign v1[0]  = v_s1;

	for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
		ddo_div_cell #(.DW(20), .NW(Q_W)) u_cell (
			.clk   (clk),
			.en    (en),
			.d_i   (wb_eff),
			.rem_i (r1[k]),
			.num_i (n1[k]),
			.rem_o (r1[k+1]),
			.num_o (n1[k+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sd1[k+1] <= sd1[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v1[k+1] <= 1'b0;
			end else if (en) begin
				v1[k+1] <= v1[k];
			end
		end
	end

	// q * INV4PI in two partial products, then their sum.
	logic [54:0]    plo_pm;
	logic [54:0]    phi_pm;
	logic [Q_W-1:0] q_pm;
	ddo_side1_t     sd_pm;
	logic           v_pm;
	logic [63:0]    prod_pa;
	logic [Q_W-1:0] q_pa;
	ddo_side1_t     sd_pa;
	logic           v_pa;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_pm  <= 55'(n1[DIV1_STEPS][25:0]) * 55'(INV4PI);
			phi_pm  <= 55'(n1[DIV1_STEPS][51:26]) * 55'(INV4PI);
			q_pm    <= n1[DIV1_STEPS];
			sd_pm   <= sd1[DIV1_STEPS];
			prod_pa <= 64'(plo_pm) + {phi_pm[37:0], 26'd0};
			q_pa    <= q_pm;
			sd_pa   <= sd_pm;
		end
	end

	// Half angle, travel direction and saturated heading change.
	logic [24:0] hraw_c;
	logic [15:0] hmag_c;
	logic [31:0] ph_c;
	logic [31:0] dir_c;
	logic [31:0] ang_s_pb;
	logic [31:0] ang_d_pb;
	ddo_side2_t  sd_pb;
	logic        v_pb;

	assign hraw_c = prod_pa[63:39];
	assign hmag_c = (q_pa[51:34] != 18'd0 || hraw_c > 25'd32768) ? 16'h8000 : hraw_c[15:0];
	assign ph_c   = prod_pa[55:24];
	assign dir_c  = sd_pa.neg ? {sd_pa.hd, 16'd0} - ph_c : {sd_pa.hd, 16'd0} + ph_c;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s_pb         <= ph_c;
			ang_d_pb         <= dir_c;
			sd_pb.q          <= q_pa;
			sd_pb.dsum       <= sd_pa.dsum;
			sd_pb.small_turn <= q_pa[51:15] == 37'd0;
			if (sd_pa.neg) begin
				sd_pb.dh <= 16'(-hmag_c);
			end else begin
				sd_pb.dh <= hmag_c[15] ? 16'h7fff : hmag_c;
			end
		end
	end

	// Two CORDIC chains: sine of the half angle, and the travel direction.
	logic signed [CW-1:0] xs [0:N];
	logic signed [CW-1:0] ys [0:N];
	logic signed [CW-1:0] zs [0:N];
	logic signed [CW-1:0] xd [0:N];
	logic signed [CW-1:0] yd [0:N];
	logic signed [CW-1:0] zd [0:N];
	ddo_side3_t           sc [0:N];
	logic                 vc [0:N];
	ddo_pre_t             pre_s;
	ddo_pre_t             pre_d;

	assign pre_s = ddo_prerot(ang_s_pb);
	assign pre_d = ddo_prerot(ang_d_pb);

	always_ff @(posedge clk) begin
		if (en) begin
			xs[0]        <= CORDIC_GAIN;
			ys[0]        <= '0;
			zs[0]        <= pre_s.z;
			xd[0]        <= CORDIC_GAIN;
			yd[0]        <= '0;
			zd[0]        <= pre_d.z;
			sc[0].b      <= sd_pb;
			sc[0].flip_s <= pre_s.flip;
			sc[0].flip_d <= pre_d.flip;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cordic
		ddo_cordic_cell #(.IDX(k)) u_sin (
			.clk (clk), .en (en),
			.x_i (xs[k]), .y_i (ys[k]), .z_i (zs[k]),
			.x_o (xs[k+1]), .y_o (ys[k+1]), .z_o (zs[k+1])
		);
		ddo_cordic_cell #(.IDX(k)) u_dir (
			.clk (clk), .en (en),
			.x_i (xd[k]), .y_i (yd[k]), .z_i (zd[k]),
			.x_o (xd[k+1]), .y_o (yd[k+1]), .z_o (zd[k+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sc[k+1] <= sc[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vc[k+1] <= 1'b0;
			end else if (en) begin
				vc[k+1] <= vc[k];
			end
		end
	end

	// Sign correction and the magnitude of the half-angle sine.
	logic signed [CW-1:0] s_c;
	logic signed [CW-1:0] sabs_c;
	logic [31:0]          sabs_cx;
	ddo_side4_t           sd_cx;
	logic                 v_cx;

	assign s_c    = sc[N].flip_s ? -ys[N] : ys[N];
	assign sabs_c = (s_c < 0) ? -s_c : s_c;

	always_ff @(posedge clk) begin
		if (en) begin
			sabs_cx     <= sabs_c[31:0];
			sd_cx.b     <= sc[N].b;
			sd_cx.s_neg <= s_c < 0;
			sd_cx.sn    <= sc[N].flip_d ? -yd[N] : yd[N];
			sd_cx.cs    <= sc[N].flip_d ? -xd[N] : xd[N];
		end
	end

	// sinc = sin(p) * 2^25 / q; the top quotient bits are known to be zero.
	logic [Q_W-1:0]        r2  [0:DIV2_STEPS];
	logic [DIV2_STEPS-1:0] n2  [0:DIV2_STEPS];
	ddo_side4_t            sd2 [0:DIV2_STEPS];
	logic                  v2  [0:DIV2_STEPS];

	assign r2[0]  = {37'd0, sabs_cx[31:17]};
	assign n2[0]  = {sabs_cx[16:0], 25'd0};
	assign sd2[0] = sd_cx;
	assign v2[0]  = v_cx;

	for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
		ddo_div_cell #(.DW(Q_W), .NW(DIV2_STEPS)) u_cell (
			.clk   (clk),
			.en    (en),
			.d_i   (sd2[k].b.q),
			.rem_i (r2[k]),
			.num_i (n2[k]),
			.rem_o (r2[k+1]),
			.num_o (n2[k+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sd2[k+1] <= sd2[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v2[k+1] <= 1'b0;
			end else if (en) begin
				v2[k+1] <= v2[k];
			end
		end
	end

	// Chord length c = d * sinc, then its projections on x and y.
	logic [DIV2_STEPS-1:0] qq_c;
	logic [30:0]           smag_c;
	logic                  sneg_c;
	logic signed [37:0]    dabs_c;
	logic [63:0]           cprod_c;
	logic [28:0]           cmag_f1;
	logic                  cneg_f1;
	logic signed [CW-1:0]  sn_f1;
	logic signed [CW-1:0]  cs_f1;
	logic [15:0]           dh_f1;
	logic                  v_f1;

	assign qq_c    = n2[DIV2_STEPS];
	assign smag_c  = sd2[DIV2_STEPS].b.small_turn ? 31'h4000_0000 :
		(qq_c > 42'h4000_0000) ? 31'h4000_0000 : qq_c[30:0];
	assign sneg_c  = !sd2[DIV2_STEPS].b.small_turn && sd2[DIV2_STEPS].s_neg && qq_c != '0;
	assign dabs_c  = (sd2[DIV2_STEPS].b.dsum < 0) ? -sd2[DIV2_STEPS].b.dsum :
		sd2[DIV2_STEPS].b.dsum;
	assign cprod_c = 64'(dabs_c[36:4]) * 64'(smag_c);

	always_ff @(posedge clk) begin
		if (en) begin
			cmag_f1 <= cprod_c[63:35];
			cneg_f1 <= (sd2[DIV2_STEPS].b.dsum < 0) != sneg_c;
			sn_f1   <= sd2[DIV2_STEPS].sn;
			cs_f1   <= sd2[DIV2_STEPS].cs;
			dh_f1   <= sd2[DIV2_STEPS].b.dh;
		end
	end

	logic signed [CW-1:0] snabs_c;
	logic signed [CW-1:0] csabs_c;
	logic [61:0]          mx_f2;
	logic [61:0]          my_f2;
	logic                 xneg_f2;
	logic                 yneg_f2;
	logic [28:0]          cmag_f2;
	logic [15:0]          dh_f2;
	logic                 v_f2;

	assign snabs_c = (sn_f1 < 0) ? -sn_f1 : sn_f1;
	assign csabs_c = (cs_f1 < 0) ? -cs_f1 : cs_f1;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_f2   <= 62'(cmag_f1) * 62'(snabs_c[32:0]);
			my_f2   <= 62'(cmag_f1) * 62'(csabs_c[32:0]);
			xneg_f2 <= cneg_f1 != (sn_f1 < 0);
			yneg_f2 <= cneg_f1 != (cs_f1 < 0);
			cmag_f2 <= cmag_f1;
			dh_f2   <= dh_f1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_cx          <= 1'b0;
			v_f1          <= 1'b0;
			v_f2          <= 1'b0;
			v_pm          <= 1'b0;
			v_pa          <= 1'b0;
			v_pb          <= 1'b0;
			vc[0]         <= 1'b0;
			odo_out.valid <= 1'b0;
		end else if (en) begin
			v_pm          <= v1[DIV1_STEPS];
			v_pa          <= v_pm;
			v_pb          <= v_pa;
			vc[0]         <= v_pb;
			v_cx          <= vc[N];
			v_f1          <= v2[DIV2_STEPS];
			v_f2          <= v_f1;
			odo_out.valid <= v_f2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			odo_out.delta_x       <= ddo_sat_sign(xneg_f2, mx_f2[61:30]);
			odo_out.delta_y       <= ddo_sat_sign(yneg_f2, my_f2[61:30]);
			odo_out.delta_heading <= signed'(dh_f2);
			odo_out.distance      <= {2'b00, cmag_f2};
		end
	end

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		odo_out.valid && !odo_out.ready |-> !odo_in.ready)
		else $error("Input accepted while a result is held.");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		odo_out.valid |-> odo_out.distance[30:29] == 2'b00)
		else $error("Chord length out of range.");

	a_zero_chord: assert property (@(posedge clk) disable iff (!arst_n)
		odo_out.valid && odo_out.distance == 31'd0 |->
		odo_out.delta_x == 32'sd0 && odo_out.delta_y == 32'sd0)
		else $error("Displacement without chord length.");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for diff_drive_odometry_step: random and directed
// encoder items checked against a bit-exact predictor held in a scoreboard.
// Depends on ddo_pkg, the ddo interfaces and the block itself.
`timescale 1ns / 1ps

module testbench;
	import ddo_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd2;
	localparam longint unsigned INV4PI_Q32 = 64'd341782638;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam int DRAIN_CYCLES = 140;

	typedef struct {
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic signed [15:0] delta_heading;
		logic [30:0]        distance;
	} odo_result_t;

	class odo_scoreboard;
		logic [19:0] dist_per_tick = DPT_RESET;
		logic [19:0] base_reg = WB_RESET;
		odo_result_t expected_q[$];
		int errors = 0;

		function void set_reg(logic [1:0] idx, logic [19:0] val);
			if (idx == REG_DPT)
				dist_per_tick = val;
			else if (idx == REG_WB)
				base_reg = val;
		endfunction

		function void rotate(logic [31:0] ang, output longint sn, output longint cs);
			longint z, x, y, t;
			bit flip;
			z = longint'(int'(ang));
			x = 64'sd652032874;
			y = 0;
			flip = 0;
			if (z > 64'sd1073741824) begin
				z -= 64'sd2147483648;
				flip = 1;
			end else if (z < -64'sd1073741824) begin
				z += 64'sd2147483648;
				flip = 1;
			end
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z -= longint'(ATAN_TURNS[i]);
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z += longint'(ATAN_TURNS[i]);
				end
				x = t;
			end
			sn = flip ? -y : y;
			cs = flip ? -x : x;
		endfunction

		function odo_result_t odometry(logic signed [15:0] lt, logic signed [15:0] rt,
				logic [15:0] hd);
			longint diff, dsum, sinc, s, cs, sn, c, dx, dy, dh;
			longint unsigned n, dpt, wb, q, dmag, smag, cmag, hmag;
			logic [31:0] ph, dir;
			bit neg;
			odo_result_t r;
			diff = longint'(lt) - longint'(rt);
			neg = diff < 0;
			n = neg ? -diff : diff;
			dpt = dist_per_tick;
			wb = (base_reg == 0) ? 1 : base_reg;
			q = ((n * dpt) << 16) / wb;
			ph = 32'((q * INV4PI_Q32) >> 24);
			dsum = (longint'(lt) + longint'(rt)) * longint'(dpt);
			dmag = dsum < 0 ? -dsum : dsum;
			if (q < 64'd32768) begin
				sinc = Q30_ONE;
			end else begin
				rotate(ph, s, cs);
				sinc = (s * 64'sd33554432) / longint'(q);
				if (sinc > Q30_ONE) sinc = Q30_ONE;
				if (sinc < -Q30_ONE) sinc = -Q30_ONE;
			end
			smag = sinc < 0 ? -sinc : sinc;
			cmag = ((dmag >> 4) * smag) >> 35;
			c = ((dsum < 0) != (sinc < 0)) ? -longint'(cmag) : longint'(cmag);
			dir = {hd, 16'h0000};
			dir = neg ? dir - ph : dir + ph;
			rotate(dir, sn, cs);
			dx = (c * sn) / Q30_ONE;
			dy = (c * cs) / Q30_ONE;
			if (dx > 64'sd2147483647) dx = 64'sd2147483647;
			if (dx < -64'sd2147483648) dx = -64'sd2147483648;
			if (dy > 64'sd2147483647) dy = 64'sd2147483647;
			if (dy < -64'sd2147483648) dy = -64'sd2147483648;
			if (q >= 64'd17179869184) begin
				hmag = 32768;
			end else begin
				hmag = (q * INV4PI_Q32) >> 39;
				if (hmag > 32768) hmag = 32768;
			end
			if (neg)
				dh = -longint'(hmag);
			else
				dh = hmag > 32767 ? 32767 : longint'(hmag);
			if (cmag > 64'd2147483647) cmag = 64'd2147483647;
			r.delta_x = dx[31:0];
			r.delta_y = dy[31:0];
			r.delta_heading = dh[15:0];
			r.distance = cmag[30:0];
			return r;
		endfunction

		function void note_item(logic signed [15:0] lt, logic signed [15:0] rt, logic [15:0] hd);
			expected_q.push_back(odometry(lt, rt, hd));
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(odo_result_t got);
			odo_result_t exp_r;
			if (expected_q.size() == 0) begin
				report("result item with nothing expected");
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.delta_x !== exp_r.delta_x)
				report($sformatf("delta_x %0d, expected %0d", got.delta_x, exp_r.delta_x));
			if (got.delta_y !== exp_r.delta_y)
				report($sformatf("delta_y %0d, expected %0d", got.delta_y, exp_r.delta_y));
			if (got.delta_heading !== exp_r.delta_heading)
				report($sformatf("delta_heading %0d, expected %0d",
					got.delta_heading, exp_r.delta_heading));
			if (got.distance !== exp_r.distance)
				report($sformatf("distance %0d, expected %0d", got.distance, exp_r.distance));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	odo_scoreboard sb = new();

	ddo_in_if  odo_in();
	ddo_out_if odo_out();
	ddo_cfg_if cfg();

	diff_drive_odometry_step u_top (
		.clk(clk),
		.arst_n(arst_n),
		.odo_in(odo_in.sink),
		.odo_out(odo_out.source),
		.cfg(cfg.sink)
	);

	initial begin
		odo_in.valid = 0;
		odo_in.left_ticks = 0;
		odo_in.right_ticks = 0;
		odo_in.heading = 0;
		odo_out.ready = 0;
		cfg.valid = 0;
		cfg.addr = REG_DPT;
		cfg.data = 0;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		odo_out.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		odo_result_t got;
		if (arst_n) begin
			if (odo_in.valid && odo_in.ready)
				sb.note_item(odo_in.left_ticks, odo_in.right_ticks, odo_in.heading);
			if (odo_out.valid && odo_out.ready) begin
				got.delta_x = odo_out.delta_x;
				got.delta_y = odo_out.delta_y;
				got.delta_heading = odo_out.delta_heading;
				got.distance = odo_out.distance;
				sb.check_result(got);
			end
		end
	end

	task automatic send_ticks(logic signed [15:0] lt, logic signed [15:0] rt, logic [15:0] hd);
		if ($urandom_range(99) < send_idle_pct) begin
			odo_in.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		odo_in.valid <= 1;
		odo_in.left_ticks <= lt;
		odo_in.right_ticks <= rt;
		odo_in.heading <= hd;
		do @(posedge clk); while (!odo_in.ready);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		cfg.valid <= 1;
		cfg.addr <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, val);
		cfg.valid <= 0;
	endtask

	task automatic drain();
		odo_in.valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random(int count);
		logic signed [15:0] lt, rt;
		int kind;
		repeat (count) begin
			kind = $urandom_range(9);
			lt = 16'($urandom);
			if (kind < 4) begin
				rt = 16'($urandom);
			end else if (kind < 8) begin
				lt = 16'($urandom_range(400)) - 16'sd200;
				rt = 16'($urandom_range(400)) - 16'sd200;
			end else begin
				rt = lt + 16'($urandom_range(6)) - 16'sd3;
			end
			send_ticks(lt, rt, 16'($urandom));
		end
	endtask

	initial begin
		static logic [19:0] dpt_set [0:6] = '{DPT_RESET, 20'd1, 20'hFFFFF, 20'hFFFFF, 20'd0,
			20'd65536, 20'd0};
		static logic [19:0] wb_set [0:6] = '{WB_RESET, 20'd256, 20'hFFFFF, 20'd256, 20'd0,
			20'd25600, 20'd0};
		static int idle_set [0:3] = '{0, 55, 0, 18};
		static int stall_set [0:3] = '{0, 0, 55, 18};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		send_ticks(0, 0, 0);
		send_ticks(16'sd32767, -16'sd32768, 16'hFFFF);
		send_ticks(-16'sd32768, 16'sd32767, 16'h0000);
		send_ticks(16'sd32767, 16'sd32767, 16'h4000);
		send_ticks(-16'sd32768, -16'sd32768, 16'h8000);
		send_ticks(100, 100, 16'hC000);
		send_ticks(-500, -500, 16'h2000);
		send_ticks(1, 0, 0);
		send_ticks(0, 1, 0);
		send_ticks(3, -3, 16'h1234);
		send_ticks(1000, -1000, 16'h0000);
		send_ticks(20000, -20000, 16'h3039);
		send_ticks(-20000, 20000, 16'hFFFF);
		send_ticks(5, 6, 16'h7FFF);
		send_ticks(300, 0, 16'h8001);
		send_ticks(0, -300, 16'hA5A5);
		send_ticks(16'sd32767, 0, 16'h5A5A);
		send_ticks(-16'sd32768, 0, 16'h0001);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 5)
				write_reg(REG_SPARE, 20'hABCDE);
			if (ph == 6) begin
				write_reg(REG_DPT, 20'($urandom_range(1, 20'hFFFFF)));
				write_reg(REG_WB, 20'($urandom_range(256, 20'hFFFFF)));
			end else if (ph > 0) begin
				write_reg(REG_DPT, dpt_set[ph]);
				write_reg(REG_WB, wb_set[ph]);
			end
			for (int m = 0; m < 4; m++) begin
				send_idle_pct = idle_set[(m + ph) % 4];
				stall_pct = stall_set[(m + ph) % 4];
				send_random(48);
			end
			send_idle_pct = 0;
			stall_pct = 0;
			drain();
		end

		if (sb.expected_q.size() > 0)
			sb.report($sformatf("%0d result items never arrived", sb.expected_q.size()));
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
